/* hdl/pmfr_pkg.sv */
// ----------------------------------------------------------------------------
// Page-mode frame buffer refresher package
// Shared types and constants: item and result payloads, item kinds, the
// controller-to-datapath command group, and the display command bytes.
// ----------------------------------------------------------------------------
package pmfr_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_SLOT  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] pixel_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] link_byte;
    logic       is_data;
    logic       frame_end;
  } result_t;

  // Commands from the controller to the datapath for one cycle.
  typedef struct packed {
    logic store_wr;  // write the item's byte at its page and column
    logic sweep_wr;  // write zero at the sweep address
    logic tick;      // refresh request
    logic slot;      // serial link can take one byte
  } cmd_t;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [3:0] NIBBLE_MASK   = 4'hF;
  localparam int         HEADER_LEN    = 3;

endpackage

/* hdl/pmfr_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pmfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/pmfr_ctrl.sv */
// ----------------------------------------------------------------------------
// Page-mode frame buffer refresher controller
// Decodes accepted transactions into datapath commands and runs the zeroing
// sweeps: the whole store after reset and one page for a page clear.
// ----------------------------------------------------------------------------
module pmfr_ctrl #(
  parameter int PAGE_COUNT   = 8,
  parameter int COLUMN_COUNT = 128
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start,
  input  pmfr_pkg::item_t                             item_i,
  output logic                                        busy,
  output pmfr_pkg::cmd_t                              cmd_o,
  output logic [$clog2(PAGE_COUNT*COLUMN_COUNT)-1:0]  sweep_addr_o
);
  import pmfr_pkg::*;

  localparam int DEPTH = PAGE_COUNT * COLUMN_COUNT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   addr_q;
  logic [AW-1:0]   last_q;
  logic            accept;
  logic            page_ok;
  logic            column_ok;
  logic [AW-1:0]   page_base;

  assign accept    = start && !busy;
  assign page_ok   = 32'(item_i.page) < PAGE_COUNT;
  assign column_ok = 32'(item_i.column) < COLUMN_COUNT;
  assign page_base = AW'(item_i.page) * AW'(COLUMN_COUNT);

  assign busy         = (state_q != ST_IDLE);
  assign sweep_addr_o = addr_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.sweep_wr = busy;
    if (accept) begin
      unique case (item_i.kind)
        KIND_WRITE: cmd_o.store_wr = page_ok && column_ok;
        KIND_CLEAR: cmd_o.store_wr = 1'b0;
        KIND_TICK:  cmd_o.tick     = 1'b1;
        KIND_SLOT:  cmd_o.slot     = 1'b1;
        default:    cmd_o          = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      addr_q  <= '0;
      last_q  <= AW'(DEPTH - 1);
    end else begin
      unique case (state_q)
        ST_INIT, ST_CLEAR: begin
          addr_q <= addr_q + AW'(1);
          if (addr_q == last_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && item_i.kind == KIND_CLEAR && page_ok) begin
            state_q <= ST_CLEAR;
            addr_q  <= page_base;
            last_q  <= page_base + AW'(COLUMN_COUNT - 1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/pmfr_datapath.sv */
// ----------------------------------------------------------------------------
// Page-mode frame buffer refresher datapath
// Frame store, refresh stream position and the registered result.
// ----------------------------------------------------------------------------
module pmfr_datapath #(
  parameter int PAGE_COUNT   = 8,
  parameter int COLUMN_COUNT = 128
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  pmfr_pkg::item_t                             item_i,
  input  pmfr_pkg::cmd_t                              cmd_i,
  input  logic [$clog2(PAGE_COUNT*COLUMN_COUNT)-1:0]  sweep_addr_i,
  output logic                                        result_valid_o,
  output pmfr_pkg::result_t                           result_o
);
  import pmfr_pkg::*;

  localparam int DEPTH = PAGE_COUNT * COLUMN_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int CW    = $clog2(COLUMN_COUNT);
  localparam int POSW  = $clog2(COLUMN_COUNT + HEADER_LEN);

  logic            pending_q, pending_d;
  logic [PW-1:0]   page_q, page_d;
  logic [POSW-1:0] pos_q, pos_d;
  logic            valid_q;
  logic            is_data_q, is_data_d;
  logic            frame_end_q, frame_end_d;
  logic [7:0]      cmd_byte_q, cmd_byte_d;

  logic            emit;
  logic            last_col;
  logic            last_page;
  logic [CW-1:0]   col;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;
  logic [7:0]      rdata;

  assign emit      = cmd_i.slot && pending_q;
  assign col       = CW'(pos_q - POSW'(HEADER_LEN));
  assign last_col  = (pos_q == POSW'(COLUMN_COUNT + HEADER_LEN - 1));
  assign last_page = (32'(page_q) == PAGE_COUNT - 1);
  assign raddr     = AW'(page_q) * AW'(COLUMN_COUNT) + AW'(col);

  assign waddr = cmd_i.sweep_wr ? sweep_addr_i
                                : AW'(item_i.page) * AW'(COLUMN_COUNT) + AW'(item_i.column);
  assign wdata = cmd_i.sweep_wr ? 8'h00 : item_i.pixel_byte;

  pmfr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_wr || cmd_i.sweep_wr),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    pending_d   = pending_q || cmd_i.tick;
    page_d      = page_q;
    pos_d       = pos_q;
    is_data_d   = is_data_q;
    frame_end_d = frame_end_q;
    cmd_byte_d  = cmd_byte_q;
    if (emit) begin
      is_data_d   = 1'b0;
      frame_end_d = 1'b0;
      pos_d       = pos_q + POSW'(1);
      priority if (pos_q == POSW'(0)) begin
        cmd_byte_d = CMD_PAGE_BASE | {4'h0, NIBBLE_MASK & 4'(page_q)};
      end else if (pos_q == POSW'(1)) begin
        cmd_byte_d = CMD_COL_LOW;
      end else if (pos_q == POSW'(2)) begin
        cmd_byte_d = CMD_COL_HIGH;
      end else begin
        is_data_d   = 1'b1;
        frame_end_d = last_col && last_page;
        if (last_col) begin
          pos_d = '0;
          if (last_page) begin
            page_d    = '0;
            pending_d = 1'b0;
          end else begin
            page_d = page_q + PW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      page_q    <= '0;
      pos_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      pending_q <= pending_d;
      page_q    <= page_d;
      pos_q     <= pos_d;
      valid_q   <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    is_data_q   <= is_data_d;
    frame_end_q <= frame_end_d;
    cmd_byte_q  <= cmd_byte_d;
  end

  // Data bytes come straight from the store's read register.
  assign result_valid_o     = valid_q;
  assign result_o.link_byte = is_data_q ? rdata : cmd_byte_q;
  assign result_o.is_data   = is_data_q;
  assign result_o.frame_end = frame_end_q;

endmodule

/* hdl/page_mode_framebuffer_refresher.sv */
// ----------------------------------------------------------------------------
// Page-mode frame buffer refresher
// Results: a byte slot taken while a refresh is pending gives its result in the
// next cycle, on result_valid_o for exactly one cycle; results cannot stall.
// Throughput: writes, ticks and slots are taken every cycle while busy is
// low; a page clear holds busy after its acceptance while it zeroes its
// page, one store entry a cycle. Reset clears control state, then busy
// stays high while a sweep zeroes the frame store.
// ----------------------------------------------------------------------------
module page_mode_framebuffer_refresher #(
  parameter int PAGE_COUNT   = 8,
  parameter int COLUMN_COUNT = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pmfr_pkg::item_t   item_i,
  output logic              result_valid_o,
  output pmfr_pkg::result_t result_o
);
  import pmfr_pkg::*;

  localparam int AW = $clog2(PAGE_COUNT * COLUMN_COUNT);

  // The controller owns the handshake and the zeroing sweeps. Every accepted
  // transaction turns into at most one command for the datapath in the same
  // cycle, so the two halves never need to talk back.
  cmd_t          cmd;
  logic [AW-1:0] sweep_addr;

  pmfr_ctrl #(
    .PAGE_COUNT   (PAGE_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .item_i       (item_i),
    .busy         (busy),
    .cmd_o        (cmd),
    .sweep_addr_o (sweep_addr)
  );

  // The datapath holds the frame store as a single-port-write RAM, the
  // refresh page and byte position, and the result register. A slot reads
  // the store in its own cycle, so data bytes see every earlier write.
  pmfr_datapath #(
    .PAGE_COUNT   (PAGE_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .sweep_addr_i   (sweep_addr),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

/* hdl/pmfr_checker.sv */
// ----------------------------------------------------------------------------
// Page-mode frame buffer refresher checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module pmfr_checker #(
  parameter int PAGE_COUNT   = 8,
  parameter int COLUMN_COUNT = 128
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input pmfr_pkg::item_t   item_i,
  input logic              result_valid_o,
  input pmfr_pkg::result_t result_o
);
  import pmfr_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // A result only ever follows an accepted byte slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept && item_i.kind == KIND_SLOT))
    else $error("result without a preceding byte slot");

  // Other transactions never produce a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.kind != KIND_SLOT) |=> !result_valid_o)
    else $error("result after a non-slot transaction");

  // The frame ends on a data byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.frame_end) |-> result_o.is_data)
    else $error("frame end on a command byte");

  // A valid page clear occupies the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.kind == KIND_CLEAR && 32'(item_i.page) < PAGE_COUNT) |=> busy)
    else $error("page clear did not raise busy");

endmodule

bind page_mode_framebuffer_refresher pmfr_checker #(
  .PAGE_COUNT   (PAGE_COUNT),
  .COLUMN_COUNT (COLUMN_COUNT)
) u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

/* dv/page_mode_framebuffer_refresher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page-mode frame buffer refresher testbench
// Drives write, clear, tick and slot transactions into the refresher. A
// predictor keeps its own copy of the frame store and refresh position, and
// every link byte from the block is checked against it in order.
// ----------------------------------------------------------------------------
module page_mode_framebuffer_refresher_tb;
  import pmfr_pkg::*;

  localparam int PAGES      = 8;
  localparam int COLUMNS    = 128;
  // Cycles with no accepted transaction and no result before the run is
  // declared hung. The reset sweep and a page clear both refuse transactions.
  localparam int HANG_LIMIT = 5000;
  // The block answers a slot in the next cycle; TAIL_WAIT adds spare time at the end.
  localparam int TAIL_WAIT  = 8;

  logic    clk_i;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  logic    result_valid_o;
  result_t result_o;

  page_mode_framebuffer_refresher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // Transactions waiting to be offered, and link bytes waiting to appear.
  item_t   cmds_to_send[$];
  result_t link_bytes_due[$];

  // Predictor state: the frame store as the block should hold it, plus the
  // refresh flag, the page being streamed and the position within that page
  // (positions 0..2 are the three command bytes, the rest are data bytes).
  logic [7:0] shadow_store [PAGES][COLUMNS];
  bit         refresh_due;
  int         stream_page;
  int         stream_pos;

  int idle_pct;
  int err_count;
  int quiet_cycles;

  // --------------------------------------------------------------------------
  // Clock and reset. Reset is applied once and released on a falling edge so
  // that it never races the block's sampling edge.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Predictor. Applies one accepted transaction to the shadow state and says
  // whether it produces a link byte, and which one. Data bytes are read from
  // the store as it stands at the slot, so writes and clears made during a
  // refresh show up in the stream. A tick while a refresh is running only
  // sets a flag that is already set, so it is lost.
  // --------------------------------------------------------------------------
  task automatic predict_link_byte(input item_t it, output bit produced,
                                   output result_t lb);
    int  col;
    bit  last_col;
    bit  last_page;
    produced = 1'b0;
    lb       = '0;
    case (it.kind)
      KIND_WRITE: begin
        if (it.page < PAGES && it.column < COLUMNS) begin
          shadow_store[it.page][it.column] = it.pixel_byte;
        end
      end
      KIND_CLEAR: begin
        if (it.page < PAGES) begin
          for (int c = 0; c < COLUMNS; c++) shadow_store[it.page][c] = 8'h00;
        end
      end
      KIND_TICK: begin
        refresh_due = 1'b1;
      end
      KIND_SLOT: begin
        if (refresh_due) begin
          produced = 1'b1;
          if (stream_pos == 0) begin
            lb.link_byte = CMD_PAGE_BASE | {4'h0, 4'(stream_page) & NIBBLE_MASK};
            stream_pos++;
          end else if (stream_pos == 1) begin
            lb.link_byte = CMD_COL_LOW;
            stream_pos++;
          end else if (stream_pos == 2) begin
            lb.link_byte = CMD_COL_HIGH;
            stream_pos++;
          end else begin
            col          = stream_pos - HEADER_LEN;
            last_col     = (col + 1 >= COLUMNS);
            last_page    = (stream_page + 1 >= PAGES);
            lb.link_byte = shadow_store[stream_page][col];
            lb.is_data   = 1'b1;
            lb.frame_end = last_col && last_page;
            if (last_col) begin
              stream_pos = 0;
              if (last_page) begin
                // End of frame: the next tick starts a new one from page 0.
                stream_page = 0;
                refresh_due = 1'b0;
              end else begin
                stream_page++;
              end
            end else begin
              stream_pos++;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver. On each falling edge it offers the oldest pending transaction,
  // unless the current phase decides to sit idle for this cycle. A refused
  // offer (busy high) is simply re-offered, since the item stays at the head
  // of the queue until the monitor sees it accepted.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && cmds_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
      start  <= 1'b1;
      item_i <= cmds_to_send[0];
    end else begin
      start  <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. On each rising edge it first checks a link byte on the result
  // ports against the oldest expectation, then runs the predictor on a
  // transaction accepted at this edge. The result of a slot arrives at the next
  // edge, so the order of the two steps never matters.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t want;
    result_t next_lb;
    bit      gives_byte;
    if (result_valid_o) begin
      quiet_cycles = 0;
      if (link_bytes_due.size() == 0) begin
        $error("link byte %0h arrived with nothing expected", result_o.link_byte);
        err_count++;
      end else begin
        want = link_bytes_due.pop_front();
        if (result_o.link_byte !== want.link_byte) begin
          $error("link_byte mismatch: expected %0h, got %0h",
                 want.link_byte, result_o.link_byte);
          err_count++;
        end
        if (result_o.is_data !== want.is_data) begin
          $error("is_data mismatch: expected %0b, got %0b",
                 want.is_data, result_o.is_data);
          err_count++;
        end
        if (result_o.frame_end !== want.frame_end) begin
          $error("frame_end mismatch: expected %0b, got %0b",
                 want.frame_end, result_o.frame_end);
          err_count++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      quiet_cycles = 0;
      predict_link_byte(item_i, gives_byte, next_lb);
      if (gives_byte) link_bytes_due.push_back(next_lb);
      void'(cmds_to_send.pop_front());
    end
  end

  // Hang detection: too many cycles in a row with no transaction either way.
  always @(posedge clk_i) begin
    quiet_cycles++;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("[page_mode_framebuffer_refresher] ERROR");
      $finish;
    end
  end

  function automatic void queue_cmd(kind_e k, int pg, int col, int pix);
    item_t it;
    it.kind       = k;
    it.page       = 3'(pg);
    it.column     = 7'(col);
    it.pixel_byte = 8'(pix);
    cmds_to_send.push_back(it);
  endfunction

  // Random traffic is mostly slots, so refreshes run deep into the frame,
  // with writes, ticks and the odd page clear mixed into the stream.
  function automatic void queue_random_cmd();
    int    roll;
    kind_e k;
    roll = $urandom_range(99);
    if (roll < 8)       k = KIND_WRITE;
    else if (roll < 10) k = KIND_CLEAR;
    else if (roll < 15) k = KIND_TICK;
    else                k = KIND_SLOT;
    queue_cmd(k, $urandom_range(7), $urandom_range(127), $urandom_range(255));
  endfunction

  // Hold off new transactions until everything queued has been accepted and
  // every expected link byte has come out. Sampled on falling edges so the
  // monitor has finished its work for the preceding rising edge.
  task automatic wait_until_drained();
    @(negedge clk_i);
    while (cmds_to_send.size() != 0 || link_bytes_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. A directed opening hits the store corners, a page clear, a slot
  // with no refresh pending, a lost tick and store changes in mid-refresh.
  // Random phases follow with different amounts of sender idling; between
  // phases the sender waits for the block to drain.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int phase_idle[4];
    phase_idle = '{0, 49, 35, 0};
    for (int p = 0; p < PAGES; p++) begin
      for (int c = 0; c < COLUMNS; c++) shadow_store[p][c] = 8'h00;
    end
    refresh_due  = 1'b0;
    stream_page  = 0;
    stream_pos   = 0;
    err_count    = 0;
    quiet_cycles = 0;
    idle_pct     = 0;

    @(posedge rst_ni);

    queue_cmd(KIND_SLOT, 0, 0, 0);       // slot with nothing pending
    queue_cmd(KIND_WRITE, 0, 0, 8'hFF);
    queue_cmd(KIND_WRITE, 7, 127, 8'hFF);
    queue_cmd(KIND_WRITE, 3, 64, 8'h5A);
    queue_cmd(KIND_WRITE, 0, 2, 8'hA5);
    queue_cmd(KIND_CLEAR, 3, 0, 0);      // wipes the 5A written above
    queue_cmd(KIND_WRITE, 3, 0, 8'h80);
    queue_cmd(KIND_WRITE, 1, 1, 8'h01);
    queue_cmd(KIND_TICK, 0, 0, 0);
    repeat (4) queue_cmd(KIND_SLOT, 0, 0, 0);
    queue_cmd(KIND_TICK, 5, 9, 8'h33);   // lost: refresh already running
    queue_cmd(KIND_WRITE, 0, 1, 8'h7E);  // column 1 not yet sent
    queue_cmd(KIND_SLOT, 7, 127, 8'hFF);
    queue_cmd(KIND_CLEAR, 0, 0, 0);      // clears the column about to go
    queue_cmd(KIND_SLOT, 0, 0, 0);
    queue_cmd(KIND_WRITE, 7, 0, 8'h00);
    queue_cmd(KIND_SLOT, 0, 0, 0);
    wait_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      repeat (235) queue_random_cmd();
      wait_until_drained();
    end
    idle_pct = 0;

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[page_mode_framebuffer_refresher] OK");
    end else begin
      $display("[page_mode_framebuffer_refresher] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/pmfr_pkg.sv
hdl/pmfr_ram.sv
hdl/pmfr_ctrl.sv
hdl/pmfr_datapath.sv
hdl/page_mode_framebuffer_refresher.sv
hdl/pmfr_checker.sv
dv/page_mode_framebuffer_refresher_tb.sv
